>>> rtl/core/nlm_pkg.sv
// nlm_pkg: shared types and constants of the nonlinear audio mixer
// no dependencies; imported by every module of the mixer
`default_nettype none

package nlm_pkg;

  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned DELTA_W     = 7;
  localparam int unsigned VOL_W       = 8;
  localparam int unsigned GAIN_W      = 15;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned NUM_STAGES  = 9;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VOL_PULSE_ONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_PULSE_TWO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_TRIANGLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_NOISE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_DELTA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd5;

  localparam logic [VOL_W-1:0]  VOL_RESET  = 8'd100;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd400;

  // floor(x / 100) as (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] VOL_RECIP   = 13'd5243;
  localparam int unsigned VOL_SHIFT   = 19;
  localparam logic [8:0]  SMALL_CAP   = 9'd15;
  localparam logic [8:0]  DELTA_CAP   = 9'd127;

  // curve numerators and denominators, integer form
  localparam logic [63:0] PULSE_NUM      = 64'd312999936;
  localparam logic [63:0] PULSE_DEN_BASE = 64'd812800;
  localparam logic [63:0] TND_NUM        = 64'd536313856;
  localparam logic [63:0] TND_DEN_BASE   = 64'd2432900;
  localparam logic [63:0] DEN_STEP       = 64'd10000;
  localparam logic [SUM_W-1:0] MIX_REST  = 17'd203;

  // floor(m / 1000) as (m * 1099511628) >> 40, exact for m below 4.9e9
  localparam logic [30:0] GAIN_RECIP = 31'd1099511628;
  localparam int unsigned GAIN_SHIFT = 40;

  typedef struct packed {
    logic [LEVEL_W-1:0] pulse_one;
    logic [LEVEL_W-1:0] pulse_two;
    logic [LEVEL_W-1:0] triangle;
    logic [LEVEL_W-1:0] noise;
    logic [DELTA_W-1:0] delta;
  } nlm_levels_t;

  typedef struct packed {
    logic [VOL_W-1:0] pulse_one;
    logic [VOL_W-1:0] pulse_two;
    logic [VOL_W-1:0] triangle;
    logic [VOL_W-1:0] noise;
    logic [VOL_W-1:0] delta;
  } nlm_volumes_t;

endpackage

`default_nettype wire

>>> rtl/core/nlm_scale.sv
// nlm_scale: volume scaling of the five channel levels, two pipeline stages
// depends on nlm_pkg
`default_nettype none

module nlm_scale (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  nlm_pkg::nlm_levels_t  levels_i,
  input  nlm_pkg::nlm_volumes_t volumes_i,
  output nlm_pkg::nlm_levels_t  levels_o
);
  import nlm_pkg::*;

  logic [11:0] prod_p1_q, prod_p2_q, prod_tr_q, prod_no_q;
  logic [14:0] prod_de_q;
  nlm_levels_t scaled_d, scaled_q;

  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [27:0] m;
    m = 28'(x) * 28'(VOL_RECIP);
    return m[VOL_SHIFT+8:VOL_SHIFT];
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_small(input logic [8:0] q);
    return (q > SMALL_CAP) ? LEVEL_W'(SMALL_CAP) : q[LEVEL_W-1:0];
  endfunction

  // stage one: level times percent
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_p1_q <= 12'(levels_i.pulse_one) * 12'(volumes_i.pulse_one);
      prod_p2_q <= 12'(levels_i.pulse_two) * 12'(volumes_i.pulse_two);
      prod_tr_q <= 12'(levels_i.triangle) * 12'(volumes_i.triangle);
      prod_no_q <= 12'(levels_i.noise) * 12'(volumes_i.noise);
      prod_de_q <= 15'(levels_i.delta) * 15'(volumes_i.delta);
    end
  end

  // stage two: floor divide by 100 and clamp
  always_comb begin
    logic [8:0] q_de;
    q_de               = div100(prod_de_q);
    scaled_d.pulse_one = clamp_small(div100(15'(prod_p1_q)));
    scaled_d.pulse_two = clamp_small(div100(15'(prod_p2_q)));
    scaled_d.triangle  = clamp_small(div100(15'(prod_tr_q)));
    scaled_d.noise     = clamp_small(div100(15'(prod_no_q)));
    scaled_d.delta     = (q_de > DELTA_CAP) ? DELTA_W'(DELTA_CAP) : q_de[DELTA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      scaled_q <= scaled_d;
    end
  end

  assign levels_o = scaled_q;

endmodule

`default_nettype wire

>>> rtl/core/nlm_curve.sv
// nlm_curve: curve indexes, constant curve tables and rest offset, three stages
// depends on nlm_pkg
`default_nettype none

module nlm_curve (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  nlm_pkg::nlm_levels_t                levels_i,
  output logic signed [nlm_pkg::SUM_W-1:0]   sum_o
);
  import nlm_pkg::*;

  localparam int unsigned PulseDepth = 32;
  localparam int unsigned TndDepth   = 256;

  logic [15:0] pulse_rom [PulseDepth];
  logic [15:0] tnd_rom   [TndDepth];

  // tables are built at elaboration from the exact integer curve formulas
  for (genvar n = 0; n < PulseDepth; n++) begin : g_pulse_rom
    localparam logic [63:0] Num = PULSE_NUM * 64'(n);
    localparam logic [63:0] Den = PULSE_DEN_BASE + DEN_STEP * 64'(n);
    localparam logic [63:0] Val = Num / Den;
    assign pulse_rom[n] = Val[15:0];
  end

  for (genvar n = 0; n < TndDepth; n++) begin : g_tnd_rom
    localparam logic [63:0] Num = TND_NUM * 64'(n);
    localparam logic [63:0] Den = TND_DEN_BASE + DEN_STEP * 64'(n);
    localparam logic [63:0] Val = Num / Den;
    assign tnd_rom[n] = Val[15:0];
  end

  logic [4:0]  pidx_q;
  logic [7:0]  tidx_q;
  logic [15:0] pulse_q, tnd_q;
  logic signed [SUM_W-1:0] sum_q;

  // stage three: pulse sum and weighted 3t + 2n + d
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pidx_q <= 5'(levels_i.pulse_one) + 5'(levels_i.pulse_two);
      tidx_q <= 8'({levels_i.triangle, 1'b0}) + 8'(levels_i.triangle)
              + 8'({levels_i.noise, 1'b0}) + 8'(levels_i.delta);
    end
  end

  // stage four: table lookup
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pulse_q <= pulse_rom[pidx_q];
      tnd_q   <= tnd_rom[tidx_q];
    end
  end

  // stage five: add curves and take off the rest offset
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sum_q <= signed'(SUM_W'(pulse_q) + SUM_W'(tnd_q) - MIX_REST);
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

>>> rtl/core/nlm_gain.sv
// nlm_gain: gain in thousandths, truncating divide by 1000 and saturation
// depends on nlm_pkg; four pipeline stages
`default_nettype none

module nlm_gain (
  input  logic                                  clk_i,
  input  logic [3:0]                            en_i,
  input  logic signed [nlm_pkg::SUM_W-1:0]      sum_i,
  input  logic [nlm_pkg::GAIN_W-1:0]            gain_i,
  output logic signed [nlm_pkg::SAMPLE_W-1:0]   sample_o
);
  import nlm_pkg::*;

  logic signed [32:0] prod_q;
  logic               neg_q, neg2_q;
  logic [29:0]        mag_q;
  logic [60:0]        recip_q;
  logic [32:0]        abs_prod;
  logic [20:0]        quot;
  logic [SAMPLE_W-1:0] sample_d, sample_q;

  // stage six: signed sum times gain
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= 33'(sum_i) * signed'({18'd0, gain_i});
    end
  end

  // stage seven: sign and magnitude, so the divide truncates toward zero
  assign abs_prod = prod_q[32] ? 33'(-prod_q) : 33'(prod_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      neg_q <= prod_q[32];
      mag_q <= abs_prod[29:0];
    end
  end

  // stage eight: magnitude times reciprocal of 1000
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      neg2_q  <= neg_q;
      recip_q <= 61'(mag_q) * 61'(GAIN_RECIP);
    end
  end

  // stage nine: shift out the fraction, apply sign, saturate
  assign quot = recip_q[GAIN_SHIFT+20:GAIN_SHIFT];

  always_comb begin
    if (neg2_q) begin
      sample_d = (quot > 21'd32768) ? 16'h8000 : 16'd0 - quot[SAMPLE_W-1:0];
    end else begin
      sample_d = (quot > 21'd32767) ? 16'h7fff : quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = signed'(sample_q);

endmodule

`default_nettype wire

>>> rtl/core/nonlinear_audio_mixer.sv
// nonlinear_audio_mixer: top level, configuration registers and pipeline control
// depends on nlm_pkg, nlm_scale, nlm_curve and nlm_gain
`default_nettype none

// Five-channel nonlinear mixer. Each transfer on the input carries the two pulse,
// triangle, noise and delta levels; each is scaled by its percent volume, the
// pulse pair and the weighted 3t+2n+d sum look up two nonlinear curves, the rest
// offset of 203 is removed, and the result is scaled by the gain register in
// thousandths (truncated toward zero) and saturated to a signed 16-bit sample. The
// block is a nine-stage pipeline: a sample may enter every cycle that the input is
// not stalled, and passes the scale, curve and gain stages in order. A stalled
// output holds the pipeline; empty stages still fill behind it. Registers
// are written through the plain write port and take effect at once; write them
// only while no sample is in flight.

module nonlinear_audio_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [nlm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [nlm_pkg::CFG_DATA_W-1:0]      cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [nlm_pkg::LEVEL_W-1:0]         pulse_one_level_i,
  input  logic [nlm_pkg::LEVEL_W-1:0]         pulse_two_level_i,
  input  logic [nlm_pkg::LEVEL_W-1:0]         triangle_level_i,
  input  logic [nlm_pkg::LEVEL_W-1:0]         noise_level_i,
  input  logic [nlm_pkg::DELTA_W-1:0]         delta_level_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [nlm_pkg::SAMPLE_W-1:0] mixed_sample_o
);
  import nlm_pkg::*;

  nlm_volumes_t       volumes_q;
  logic [GAIN_W-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volumes_q.pulse_one <= VOL_RESET;
      volumes_q.pulse_two <= VOL_RESET;
      volumes_q.triangle  <= VOL_RESET;
      volumes_q.noise     <= VOL_RESET;
      volumes_q.delta     <= VOL_RESET;
      gain_q              <= GAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VOL_PULSE_ONE: volumes_q.pulse_one <= cfg_data_i[VOL_W-1:0];
        REG_VOL_PULSE_TWO: volumes_q.pulse_two <= cfg_data_i[VOL_W-1:0];
        REG_VOL_TRIANGLE:  volumes_q.triangle  <= cfg_data_i[VOL_W-1:0];
        REG_VOL_NOISE:     volumes_q.noise     <= cfg_data_i[VOL_W-1:0];
        REG_VOL_DELTA:     volumes_q.delta     <= cfg_data_i[VOL_W-1:0];
        REG_GAIN:          gain_q              <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits per stage; a stage loads when empty or when the next one moves
  logic [NUM_STAGES-1:0] valid_q, valid_d, en;

  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) valid_q[k] <= valid_d[k];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  nlm_levels_t             raw_levels, scaled_levels;
  logic signed [SUM_W-1:0] mix_sum;

  assign raw_levels.pulse_one = pulse_one_level_i;
  assign raw_levels.pulse_two = pulse_two_level_i;
  assign raw_levels.triangle  = triangle_level_i;
  assign raw_levels.noise     = noise_level_i;
  assign raw_levels.delta     = delta_level_i;

  nlm_scale u_scale (
    .clk_i     (clk_i),
    .en_i      (en[1:0]),
    .levels_i  (raw_levels),
    .volumes_i (volumes_q),
    .levels_o  (scaled_levels)
  );

  nlm_curve u_curve (
    .clk_i    (clk_i),
    .en_i     (en[4:2]),
    .levels_i (scaled_levels),
    .sum_o    (mix_sum)
  );

  nlm_gain u_gain (
    .clk_i    (clk_i),
    .en_i     (en[8:5]),
    .sum_i    (mix_sum),
    .gain_i   (gain_q),
    .sample_o (mixed_sample_o)
  );

endmodule

`default_nettype wire
